// ===== rtl/viscous_face_flux_unit_defines.svh =====
// Assertion helpers for the RTL top level.
`ifndef VISCOUS_FACE_FLUX_UNIT_DEFINES_SVH
`define VISCOUS_FACE_FLUX_UNIT_DEFINES_SVH

// Overlapping implication, off while reset is high.
`define VFF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset too.
`define VFF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vff_pkg.sv =====
package vff_pkg;

  localparam int DATA_W  = 32;
  localparam int NORM_W  = 18;
  localparam int COEF_W  = 31;
  localparam int FAC_W   = 32;
  localparam int T_W     = 48;
  localparam int WIDE_W  = 68;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int LATENCY = 8;

  // 4/3 and 2/3 in Q16.16
  localparam logic [16:0] THIRD4 = 17'd87381;
  localparam logic [16:0] THIRD2 = 17'd43691;

  // register select (paddr word bit)
  localparam logic REG_SHEAR = 1'b0;
  localparam logic REG_BULK  = 1'b1;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic signed [NORM_W-1:0] norm_t;
  typedef logic signed [T_W-1:0]    t_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [FAC_W-1:0]  fac1;
    logic [FAC_W-1:0]  fac2;
    logic [COEF_W-1:0] mu;
    logic [COEF_W-1:0] zeta;
  } coef_t;

  typedef struct packed {
    logic  valid;
    t_t    xx;
    t_t    yy;
    t_t    zz;
    t_t    xy;
    t_t    xz;
    t_t    yz;
    norm_t nx;
    norm_t ny;
    norm_t nz;
    q_t    vx;
    q_t    vy;
    q_t    vz;
  } stress_t;

  typedef struct packed {
    logic valid;
    t_t   mx;
    t_t   my;
    t_t   mz;
    q_t   vx;
    q_t   vy;
    q_t   vz;
  } mom_t;

  localparam wide_t HALF  = wide_t'(32768);
  localparam wide_t T_MAX = wide_t'({1'b0, {(T_W-1){1'b1}}});
  localparam wide_t T_MIN = -T_MAX - wide_t'(1);
  localparam wide_t Q_MAX = wide_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam wide_t Q_MIN = -Q_MAX - wide_t'(1);

  // Q16.16 product rounding, half up
  function automatic wide_t rnd16(wide_t p);
    return (p + HALF) >>> 16;
  endfunction

  function automatic t_t sat_t(wide_t x);
    wide_t r;
    if (x > T_MAX) r = T_MAX;
    else if (x < T_MIN) r = T_MIN;
    else r = x;
    return r[T_W-1:0];
  endfunction

  function automatic q_t sat_q(wide_t x);
    wide_t r;
    if (x > Q_MAX) r = Q_MAX;
    else if (x < Q_MIN) r = Q_MIN;
    else r = x;
    return r[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/vff_cfg.sv =====
module vff_cfg import vff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output coef_t             coef
);

  logic [COEF_W-1:0] shear_viscosity;
  logic [COEF_W-1:0] bulk_viscosity;
  logic [COEF_W+16:0] fac1_prod;
  logic [COEF_W+16:0] fac2_prod;
  logic               reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[APB_AW-1];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shear_viscosity <= '0;
      bulk_viscosity  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SHEAR: shear_viscosity <= pwdata[COEF_W-1:0];
        REG_BULK:  bulk_viscosity  <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHEAR: prdata = {{(APB_DW-COEF_W){1'b0}}, shear_viscosity};
      REG_BULK:  prdata = {{(APB_DW-COEF_W){1'b0}}, bulk_viscosity};
      default:   prdata = '0;
    endcase
  end

  // mu * 4/3 and mu * 2/3, rounded
  assign fac1_prod = shear_viscosity * THIRD4 + (COEF_W+17)'(32768);
  assign fac2_prod = shear_viscosity * THIRD2 + (COEF_W+17)'(32768);

  always_ff @(posedge clk) begin
    coef.fac1 <= fac1_prod[COEF_W+16:16];
    coef.fac2 <= fac2_prod[COEF_W+16:16];
    coef.mu   <= shear_viscosity;
    coef.zeta <= bulk_viscosity;
  end

endmodule

// ===== rtl/vff_stress.sv =====
module vff_stress import vff_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  coef_t   coef,
  input  q_t      grad_xx,
  input  q_t      grad_yy,
  input  q_t      grad_zz,
  input  q_t      shear_xy,
  input  q_t      shear_xz,
  input  q_t      shear_yz,
  input  norm_t   normal_x,
  input  norm_t   normal_y,
  input  norm_t   normal_z,
  input  q_t      face_vel_x,
  input  q_t      face_vel_y,
  input  q_t      face_vel_z,
  output stress_t stress
);

  // stage 1: operand prep
  logic valid1;
  q_t   gx1, gy1, gz1, sxy1, sxz1, syz1;
  logic signed [DATA_W:0]   ox1, oy1, oz1;
  logic signed [DATA_W+1:0] dv1;
  norm_t nx1, ny1, nz1;
  q_t    vx1, vy1, vz1;

  // stage 2: raw products
  logic valid2;
  logic signed [2*DATA_W:0]   pax2, pay2, paz2, pbx2, pby2, pbz2;
  logic signed [2*DATA_W+1:0] pdv2;
  logic signed [2*DATA_W-1:0] pxy2, pxz2, pyz2;
  norm_t nx2, ny2, nz2;
  q_t    vx2, vy2, vz2;

  wide_t rdv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
    end else begin
      valid1 <= in_valid;
      valid2 <= valid1;
    end
  end

  always_ff @(posedge clk) begin
    gx1  <= grad_xx;
    gy1  <= grad_yy;
    gz1  <= grad_zz;
    ox1  <= grad_yy + grad_zz;
    oy1  <= grad_xx + grad_zz;
    oz1  <= grad_xx + grad_yy;
    dv1  <= grad_xx + grad_yy + grad_zz;
    sxy1 <= shear_xy;
    sxz1 <= shear_xz;
    syz1 <= shear_yz;
    nx1  <= normal_x;
    ny1  <= normal_y;
    nz1  <= normal_z;
    vx1  <= face_vel_x;
    vy1  <= face_vel_y;
    vz1  <= face_vel_z;
  end

  always_ff @(posedge clk) begin
    pax2 <= gx1 * $signed({1'b0, coef.fac1});
    pay2 <= gy1 * $signed({1'b0, coef.fac1});
    paz2 <= gz1 * $signed({1'b0, coef.fac1});
    pbx2 <= ox1 * $signed({1'b0, coef.fac2});
    pby2 <= oy1 * $signed({1'b0, coef.fac2});
    pbz2 <= oz1 * $signed({1'b0, coef.fac2});
    pdv2 <= dv1 * $signed({1'b0, coef.zeta});
    pxy2 <= sxy1 * $signed({1'b0, coef.mu});
    pxz2 <= sxz1 * $signed({1'b0, coef.mu});
    pyz2 <= syz1 * $signed({1'b0, coef.mu});
    nx2  <= nx1;
    ny2  <= ny1;
    nz2  <= nz1;
    vx2  <= vx1;
    vy2  <= vy1;
    vz2  <= vz1;
  end

  // bulk term is common to all diagonal entries
  assign rdv = rnd16(wide_t'(pdv2));

  always_ff @(posedge clk) begin
    if (rst) begin
      stress.valid <= 1'b0;
    end else begin
      stress.valid <= valid2;
    end
    stress.xx <= sat_t(rnd16(wide_t'(pax2)) - rnd16(wide_t'(pbx2)) + rdv);
    stress.yy <= sat_t(rnd16(wide_t'(pay2)) - rnd16(wide_t'(pby2)) + rdv);
    stress.zz <= sat_t(rnd16(wide_t'(paz2)) - rnd16(wide_t'(pbz2)) + rdv);
    stress.xy <= sat_t(rnd16(wide_t'(pxy2)));
    stress.xz <= sat_t(rnd16(wide_t'(pxz2)));
    stress.yz <= sat_t(rnd16(wide_t'(pyz2)));
    stress.nx <= nx2;
    stress.ny <= ny2;
    stress.nz <= nz2;
    stress.vx <= vx2;
    stress.vy <= vy2;
    stress.vz <= vz2;
  end

endmodule

// ===== rtl/vff_momentum.sv =====
module vff_momentum import vff_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  stress_t stress,
  output mom_t    mom
);

  t_t    tmat [3][3];
  norm_t nvec [3];

  // stage 4: n_j * t_ij
  logic valid4;
  logic signed [NORM_W+T_W-1:0] prod4 [3][3];
  q_t vx4, vy4, vz4;

  always_comb begin
    tmat[0][0] = stress.xx;
    tmat[0][1] = stress.xy;
    tmat[0][2] = stress.xz;
    tmat[1][0] = stress.xy;
    tmat[1][1] = stress.yy;
    tmat[1][2] = stress.yz;
    tmat[2][0] = stress.xz;
    tmat[2][1] = stress.yz;
    tmat[2][2] = stress.zz;
    nvec[0]    = stress.nx;
    nvec[1]    = stress.ny;
    nvec[2]    = stress.nz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
    end else begin
      valid4 <= stress.valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod4[i][j] <= nvec[j] * tmat[i][j];
      end
    end
    vx4 <= stress.vx;
    vy4 <= stress.vy;
    vz4 <= stress.vz;
  end

  // stage 5: row sums, saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      mom.valid <= 1'b0;
    end else begin
      mom.valid <= valid4;
    end
    mom.mx <= sat_t(rnd16(wide_t'(prod4[0][0])) + rnd16(wide_t'(prod4[0][1]))
                    + rnd16(wide_t'(prod4[0][2])));
    mom.my <= sat_t(rnd16(wide_t'(prod4[1][0])) + rnd16(wide_t'(prod4[1][1]))
                    + rnd16(wide_t'(prod4[1][2])));
    mom.mz <= sat_t(rnd16(wide_t'(prod4[2][0])) + rnd16(wide_t'(prod4[2][1]))
                    + rnd16(wide_t'(prod4[2][2])));
    mom.vx <= vx4;
    mom.vy <= vy4;
    mom.vz <= vz4;
  end

endmodule

// ===== rtl/vff_energy.sv =====
module vff_energy import vff_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  mom_t mom,
  output logic done,
  output q_t   momentum_flux_x,
  output q_t   momentum_flux_y,
  output q_t   momentum_flux_z,
  output q_t   energy_flux
);

  t_t mvec [3];
  q_t vvec [3];

  // stage 6: v * m split into high and low halves of m
  logic valid6;
  logic signed [2*DATA_W-1:0] phi6 [3];
  logic signed [DATA_W+16:0]  plo6 [3];
  t_t   m6 [3];

  // stage 7: per-axis energy terms
  logic valid7;
  t_t   e7 [3];
  t_t   m7 [3];

  always_comb begin
    mvec[0] = mom.mx;
    mvec[1] = mom.my;
    mvec[2] = mom.mz;
    vvec[0] = mom.vx;
    vvec[1] = mom.vy;
    vvec[2] = mom.vz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid6 <= 1'b0;
      valid7 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid6 <= mom.valid;
      valid7 <= valid6;
      done   <= valid7;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      phi6[i] <= vvec[i] * $signed(mvec[i][T_W-1:16]);
      plo6[i] <= vvec[i] * $signed({1'b0, mvec[i][15:0]});
      m6[i]   <= mvec[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e7[i] <= sat_t(wide_t'(phi6[i]) + rnd16(wide_t'(plo6[i])));
      m7[i] <= m6[i];
    end
  end

  always_ff @(posedge clk) begin
    momentum_flux_x <= sat_q(wide_t'(m7[0]));
    momentum_flux_y <= sat_q(wide_t'(m7[1]));
    momentum_flux_z <= sat_q(wide_t'(m7[2]));
    energy_flux     <= sat_q(wide_t'(e7[0]) + wide_t'(e7[1]) + wide_t'(e7[2]));
  end

endmodule

// ===== rtl/viscous_face_flux_unit.sv =====
// Viscous face flux unit. Takes one cell face per clock (start while busy is
// low) and returns its three viscous momentum-flux increments and the energy
// increment, all saturated signed Q16.16, on done: done is high for one cycle
// per face taken. Each face passes through the eight-register pipeline
// (operand prep, stress products, stress sums, normal products, momentum
// sums, energy products, energy terms, output). There is no backpressure:
// results must be captured when done is high. busy is high only while rst is.
// Viscosities are written over APB (shear at 0x0, bulk at 0x4) and should
// only be changed while no face is in flight.
`include "viscous_face_flux_unit_defines.svh"

module viscous_face_flux_unit import vff_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // APB config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // face word in
  input  logic              start,
  output logic              busy,
  input  q_t                grad_xx,
  input  q_t                grad_yy,
  input  q_t                grad_zz,
  input  q_t                shear_xy,
  input  q_t                shear_xz,
  input  q_t                shear_yz,
  input  norm_t             normal_x,
  input  norm_t             normal_y,
  input  norm_t             normal_z,
  input  q_t                face_vel_x,
  input  q_t                face_vel_y,
  input  q_t                face_vel_z,
  // flux word out
  output logic              done,
  output q_t                momentum_flux_x,
  output q_t                momentum_flux_y,
  output q_t                momentum_flux_z,
  output q_t                energy_flux
);

  coef_t   coef;
  stress_t stress;
  mom_t    mom;
  logic    accept;

  // Pipeline never stalls; only hold off faces while reset flushes it.
  assign busy   = rst;
  assign accept = start & ~busy;

  // Config registers plus mu*4/3 and mu*2/3, registered from the shear register.
  vff_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // Stages 1-3: stress tensor (diagonal with bulk term, off-diagonal shear).
  vff_stress u_stress (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .coef       (coef),
    .grad_xx    (grad_xx),
    .grad_yy    (grad_yy),
    .grad_zz    (grad_zz),
    .shear_xy   (shear_xy),
    .shear_xz   (shear_xz),
    .shear_yz   (shear_yz),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .face_vel_x (face_vel_x),
    .face_vel_y (face_vel_y),
    .face_vel_z (face_vel_z),
    .stress     (stress)
  );

  // Stages 4-5: project the tensor onto the face normal.
  vff_momentum u_momentum (
    .clk    (clk),
    .rst    (rst),
    .stress (stress),
    .mom    (mom)
  );

  // Stages 6-8: dot with face velocity, final 32-bit saturation.
  vff_energy u_energy (
    .clk             (clk),
    .rst             (rst),
    .mom             (mom),
    .done            (done),
    .momentum_flux_x (momentum_flux_x),
    .momentum_flux_y (momentum_flux_y),
    .momentum_flux_z (momentum_flux_z),
    .energy_flux     (energy_flux)
  );

  // Every accepted face comes out on done, and nothing else does.
  `VFF_ASSERT_IMPLY(a_face_latency, start && !busy, ##LATENCY done, "face result missing")
  `VFF_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, LATENCY), "unexpected result")
  `VFF_ASSERT_NEXT(a_reset_flush, rst, !done, "result after reset")

endmodule

// ===== tb/tb.sv =====
module tb import vff_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Wide signed scratch type for the flux model. The largest exact product
  // is a 32-bit operand times a 48-bit one, so 96 bits never wrap.
  typedef logic signed [95:0] acc_t;

  // One face word as the sender holds it. idle_before is the gap the sender
  // leaves ahead of the word; drain makes the sender hold the word until
  // every flux in flight has come back.
  typedef struct {
    q_t    gxx, gyy, gzz;
    q_t    sxy, sxz, syz;
    norm_t nx, ny, nz;
    q_t    vx, vy, vz;
    int    idle_before;
    bit    drain;
  } face_t;

  typedef struct {
    q_t mx, my, mz, e;
  } flux_t;

  localparam acc_t FOUR_THIRDS = 87381;  // 4/3 in Q16.16
  localparam acc_t TWO_THIRDS  = 43691;  // 2/3 in Q16.16
  localparam acc_t ROUND_HALF  = 32768;
  localparam acc_t LIM48_HI    = (acc_t'(1) <<< 47) - 1;
  localparam acc_t LIM48_LO    = -(acc_t'(1) <<< 47);
  localparam acc_t LIM32_HI    = (acc_t'(1) <<< 31) - 1;
  localparam acc_t LIM32_LO    = -(acc_t'(1) <<< 31);

  localparam q_t    Q_ONE  = 32'sh0001_0000;
  localparam q_t    Q_HALF = 32'sh0000_8000;
  localparam q_t    Q_TWO  = 32'sh0002_0000;
  localparam q_t    Q_TOP  = 32'sh7FFF_FFFF;
  localparam q_t    Q_BOT  = q_t'(32'h8000_0000);
  localparam norm_t N_ONE  = 18'sh1_0000;
  localparam norm_t N_HALF = 18'sh0_8000;
  localparam norm_t N_TOP  = 18'sh1_FFFF;
  localparam norm_t N_BOT  = norm_t'(18'h2_0000);

  // Watchdog limit, far beyond the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          MAX_PRINTS  = 40;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  q_t                grad_xx = '0;
  q_t                grad_yy = '0;
  q_t                grad_zz = '0;
  q_t                shear_xy = '0;
  q_t                shear_xz = '0;
  q_t                shear_yz = '0;
  norm_t             normal_x = '0;
  norm_t             normal_y = '0;
  norm_t             normal_z = '0;
  q_t                face_vel_x = '0;
  q_t                face_vel_y = '0;
  q_t                face_vel_z = '0;
  logic              done;
  q_t                momentum_flux_x;
  q_t                momentum_flux_y;
  q_t                momentum_flux_z;
  q_t                energy_flux;

  viscous_face_flux_unit DUT (.*);

  // Testbench copy of the two viscosity registers (31-bit, reset 0).
  logic [30:0] shear_coef = '0;
  logic [30:0] bulk_coef = '0;

  face_t face_q[$];    // face words waiting for the sender
  flux_t flux_q[$];    // predicted flux words, oldest first
  face_t on_port;      // word currently presented with start
  int    gap_left = 0;
  bit    gap_spent = 1'b0;
  int    mismatches = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Flux model
  // ------------------------------------------------------------------

  // Q16.16 product, exact then rounded half up (floor of x + 1/2).
  function automatic acc_t qmul(acc_t a, acc_t b);
    return (a * b + ROUND_HALF) >>> 16;
  endfunction

  function automatic acc_t clamp48(acc_t x);
    if (x > LIM48_HI) return LIM48_HI;
    if (x < LIM48_LO) return LIM48_LO;
    return x;
  endfunction

  function automatic q_t clamp32(acc_t x);
    acc_t c;
    c = x;
    if (c > LIM32_HI) c = LIM32_HI;
    if (c < LIM32_LO) c = LIM32_LO;
    return q_t'(c[31:0]);
  endfunction

  // Stress tensor from the gradient, projected on the normal (momentum flux),
  // then dotted with the face velocity (energy flux). Every stress, every
  // momentum term and every energy product clips at 48 bits before use, so
  // later cancellation cannot undo an earlier clip.
  function automatic flux_t viscous_flux(face_t f);
    acc_t  g[3], n[3], v[3], m[3];
    acc_t  t[3][3];
    acc_t  mu, zeta, fac43, fac23, dv, sum, energy;
    flux_t r;
    int    i, j;
    g[0] = f.gxx; g[1] = f.gyy; g[2] = f.gzz;
    n[0] = f.nx;  n[1] = f.ny;  n[2] = f.nz;
    v[0] = f.vx;  v[1] = f.vy;  v[2] = f.vz;
    mu    = shear_coef;
    zeta  = bulk_coef;
    fac43 = (mu * FOUR_THIRDS + ROUND_HALF) >>> 16;
    fac23 = (mu * TWO_THIRDS + ROUND_HALF) >>> 16;
    dv    = g[0] + g[1] + g[2];
    for (i = 0; i < 3; i++)
      t[i][i] = clamp48(qmul(g[i], fac43) - qmul(fac23, dv - g[i]) + qmul(zeta, dv));
    t[0][1] = clamp48(qmul(acc_t'(f.sxy), mu));
    t[0][2] = clamp48(qmul(acc_t'(f.sxz), mu));
    t[1][2] = clamp48(qmul(acc_t'(f.syz), mu));
    t[1][0] = t[0][1];
    t[2][0] = t[0][2];
    t[2][1] = t[1][2];
    energy = 0;
    for (i = 0; i < 3; i++) begin
      sum = 0;
      for (j = 0; j < 3; j++)
        sum += qmul(n[j], t[i][j]);
      m[i] = clamp48(sum);
      energy += clamp48(qmul(v[i], m[i]));
    end
    r.mx = clamp32(m[0]);
    r.my = clamp32(m[1]);
    r.mz = clamp32(m[2]);
    r.e  = clamp32(energy);
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  function automatic face_t mk_face(q_t gxx, q_t gyy, q_t gzz, q_t sxy, q_t sxz, q_t syz,
                                    norm_t nx, norm_t ny, norm_t nz,
                                    q_t vx, q_t vy, q_t vz);
    face_t f;
    f.gxx = gxx; f.gyy = gyy; f.gzz = gzz;
    f.sxy = sxy; f.sxz = sxz; f.syz = syz;
    f.nx = nx;   f.ny = ny;   f.nz = nz;
    f.vx = vx;   f.vy = vy;   f.vz = vz;
    f.idle_before = 0;
    f.drain = 1'b0;
    return f;
  endfunction

  // Mostly moderate magnitudes so the pipeline does real arithmetic rather
  // than clipping every word; extremes and full-range noise mixed in.
  function automatic q_t rand_q();
    q_t          r;
    int unsigned mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: r = Q_TOP;
          1: r = Q_BOT;
          2: r = '0;
          3: r = -1;
          default: r = 1;
        endcase
      end
      1, 2, 3: r = $urandom;
      default: begin
        mag = $urandom_range(0, 1 << $urandom_range(2, 22));
        r = $urandom_range(0, 1) ? -q_t'(mag) : q_t'(mag);
      end
    endcase
    return r;
  endfunction

  // Unit range most of the time; the whole 18-bit range now and then, since
  // a non-unit normal is taken as given.
  function automatic norm_t rand_n();
    norm_t r;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: r = N_ONE;
          1: r = -N_ONE;
          2: r = N_TOP;
          3: r = N_BOT;
          default: r = '0;
        endcase
      end
      1: r = norm_t'($urandom);
      default: r = norm_t'(int'($urandom_range(0, 131072)) - 65536);
    endcase
    return r;
  endfunction

  // Coefficient for pwdata; bit 31 is random and must be dropped by the block.
  function automatic logic [31:0] rand_coef();
    logic [31:0] c;
    case ($urandom_range(0, 4))
      0: c = 32'h7FFF_FFFF;
      1: c = '0;
      2, 3: c = $urandom_range(0, 1 << 18);  // up to 4.0
      default: c = $urandom;
    endcase
    c[31] = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // Phases without idling get no random drain pauses either.
  task automatic queue_random_faces(int count, int idle_pct, bit force_drain);
    face_t f;
    int    k;
    for (k = 0; k < count; k++) begin
      f = mk_face(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                  rand_n(), rand_n(), rand_n(), rand_q(), rand_q(), rand_q());
      if (int'($urandom_range(1, 100)) <= idle_pct)
        f.idle_before = $urandom_range(1, 16);
      f.drain = (force_drain && k == count / 2) ||
                (idle_pct > 0 && $urandom_range(0, 199) == 0);
      face_q.push_back(f);
    end
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] ERROR: %s", $realtime, msg);
    mismatches++;
  endtask

  // ------------------------------------------------------------------
  // APB access: setup cycle, then access cycle; pready is tied high.
  // ------------------------------------------------------------------

  task automatic reg_write(logic sel, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // register takes the word at this edge
    if (sel == REG_SHEAR) shear_coef = data[30:0];
    else bulk_coef = data[30:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(logic sel);
    logic [31:0] want;
    want = (sel == REG_SHEAR) ? {1'b0, shear_coef} : {1'b0, bulk_coef};
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("prdata at %0h got %h want %h", {sel, 2'b00}, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_coefs(logic [31:0] mu_w, logic [31:0] zeta_w);
    reg_write(REG_SHEAR, mu_w);
    reg_write(REG_BULK, zeta_w);
    reg_read(REG_SHEAR);
    reg_read(REG_BULK);
  endtask

  // Sampled on the falling edge so the posedge processes have all settled.
  // Every face yields a flux word, so once nothing is owed the pipe is empty;
  // the extra latency is only margin before registers change.
  task automatic wait_quiet();
    do @(negedge clk); while (face_q.size() != 0 || start || flux_q.size() != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Sender: presents queued face words on start. A word is taken at the
  // edge where start is high and busy is low; its flux is predicted then,
  // with the register copy that is live for it.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start)
        flux_q.push_back(viscous_flux(on_port));
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (face_q.size() == 0) begin
        start <= 1'b0;
      end else if (!gap_spent && face_q[0].idle_before > 0) begin
        gap_left  = face_q[0].idle_before - 1;
        gap_spent = 1'b1;
        start <= 1'b0;
      end else if (face_q[0].drain && (flux_q.size() != 0 || done)) begin
        // hold off until the pipe has handed back everything in flight
        start <= 1'b0;
      end else begin
        on_port   = face_q.pop_front();
        gap_spent = 1'b0;
        grad_xx    <= on_port.gxx;
        grad_yy    <= on_port.gyy;
        grad_zz    <= on_port.gzz;
        shear_xy   <= on_port.sxy;
        shear_xz   <= on_port.sxz;
        shear_yz   <= on_port.syz;
        normal_x   <= on_port.nx;
        normal_y   <= on_port.ny;
        normal_z   <= on_port.nz;
        face_vel_x <= on_port.vx;
        face_vel_y <= on_port.vy;
        face_vel_z <= on_port.vz;
        start <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: done marks a flux word for one cycle, no stalling possible.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    flux_t want;
    if (!rst && done) begin
      if (flux_q.size() == 0) begin
        report_mismatch("flux word with nothing outstanding");
      end else begin
        want = flux_q.pop_front();
        if (momentum_flux_x !== want.mx)
          report_mismatch($sformatf("momentum_flux_x got %h want %h",
                                    momentum_flux_x, want.mx));
        if (momentum_flux_y !== want.my)
          report_mismatch($sformatf("momentum_flux_y got %h want %h",
                                    momentum_flux_y, want.my));
        if (momentum_flux_z !== want.mz)
          report_mismatch($sformatf("momentum_flux_z got %h want %h",
                                    momentum_flux_z, want.mz));
        if (energy_flux !== want.e)
          report_mismatch($sformatf("energy_flux got %h want %h", energy_flux, want.e));
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("viscous_face_flux_unit test failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------
  initial begin : sequencer
    int          p;
    logic [31:0] mu_w, zeta_w;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset values: both coefficients zero, so every flux is zero.
    reg_read(REG_SHEAR);
    reg_read(REG_BULK);
    face_q.push_back(mk_face(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                             N_ONE, N_ONE, N_ONE, Q_TOP, Q_TOP, Q_TOP));
    face_q.push_back(mk_face(Q_ONE, -Q_ONE, Q_HALF, Q_ONE, Q_BOT, 1,
                             N_ONE, 0, -N_ONE, Q_ONE, Q_ONE, Q_ONE));
    wait_quiet();

    // mu = 1.0, zeta = 0.5; bit 31 of the bulk write must be dropped.
    set_coefs(32'h0001_0000, 32'h8000_8000);
    face_q.push_back(mk_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // pure shear on an x face moving along y
    face_q.push_back(mk_face(0, 0, 0, Q_ONE, 0, 0, N_ONE, 0, 0, 0, Q_ONE, 0));
    // isotropic dilation through a z face
    face_q.push_back(mk_face(Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, N_ONE, 0, 0, Q_TWO));
    face_q.push_back(mk_face(-Q_ONE, Q_HALF, 0, 0, Q_HALF, -Q_HALF,
                             -N_ONE, 0, 0, Q_ONE, -Q_ONE, Q_HALF));
    // non-unit normal, used without normalization
    face_q.push_back(mk_face(Q_ONE, -Q_ONE, Q_HALF, Q_ONE, Q_ONE, Q_ONE,
                             N_TOP, N_BOT, 18'sh1_0001, Q_ONE, Q_ONE, Q_ONE));
    // single-LSB terms exercise half-up rounding
    face_q.push_back(mk_face(1, -1, 1, 1, -1, 1, N_HALF, -N_HALF, 1, 1, -1, 32'sh0000_7FFF));
    // output clipping, both signs
    face_q.push_back(mk_face(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                             N_ONE, N_ONE, N_ONE, Q_TOP, Q_TOP, Q_TOP));
    face_q.push_back(mk_face(Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT,
                             -N_ONE, -N_ONE, -N_ONE, Q_BOT, Q_BOT, Q_BOT));
    face_q.push_back(mk_face(Q_TOP, Q_BOT, Q_TOP, Q_BOT, Q_TOP, Q_BOT,
                             N_ONE, -N_ONE, N_ONE, Q_BOT, Q_TOP, Q_BOT));
    face_q.push_back(mk_face(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    wait_quiet();

    // Largest coefficients: stresses and products hit the 48-bit clip.
    set_coefs(32'hFFFF_FFFF, 32'h7FFF_FFFF);
    face_q.push_back(mk_face(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP,
                             N_TOP, N_TOP, N_TOP, Q_TOP, Q_TOP, Q_TOP));
    face_q.push_back(mk_face(Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT, Q_BOT,
                             N_BOT, N_BOT, N_BOT, Q_BOT, Q_BOT, Q_BOT));
    // two clipped energy terms of opposite sign cancel after the clip
    face_q.push_back(mk_face(Q_TOP, Q_TOP, Q_TOP, Q_TOP, 0, 0,
                             N_ONE, N_ONE, 0, Q_TOP, Q_BOT, 0));
    face_q.push_back(mk_face(Q_TOP, Q_BOT, 0, Q_BOT, Q_TOP, Q_BOT,
                             N_ONE, N_ONE, -N_ONE, Q_ONE, -Q_ONE, Q_HALF));
    face_q.push_back(mk_face(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    face_q.push_back(mk_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    face_q.push_back(mk_face(Q_ONE, -Q_ONE, 0, Q_HALF, -Q_HALF, Q_ONE,
                             N_HALF, N_HALF, -N_HALF, Q_TOP, Q_BOT, Q_ONE));
    wait_quiet();

    // Random phases: fixed corner settings first, then random ones. Some
    // phases run with no sender gaps, including the last one.
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin mu_w = 32'h7FFF_FFFF; zeta_w = 32'hFFFF_FFFF; end
        1: begin mu_w = 32'h0000_0000; zeta_w = 32'h7FFF_FFFF; end
        2: begin mu_w = 32'h7FFF_FFFF; zeta_w = 32'h0000_0000; end
        3: begin mu_w = 32'h8000_0000; zeta_w = 32'h0000_0000; end
        default: begin mu_w = rand_coef(); zeta_w = rand_coef(); end
      endcase
      set_coefs(mu_w, zeta_w);
      queue_random_faces(200, (p % 3 == 1 || p == 7) ? 0 : 20, p == 0);
      wait_quiet();
    end

    repeat (4) @(posedge clk);
    if (mismatches == 0 && flux_q.size() == 0) begin
      $display("viscous_face_flux_unit test passed");
    end else begin
      $display("viscous_face_flux_unit test failed");
    end
    $finish;
  end

endmodule
